@@ design/iar_pkg.sv @@
`default_nettype none

package iar_pkg;

    // Word and digit store geometry
    localparam int WORD_BITS  = 32;
    localparam int MAX_DIGITS = 32;
    localparam int IDX_W      = $clog2(MAX_DIGITS);
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

    // Divider: quotient bits retired per cycle and steps per digit
    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = (WORD_BITS + DIV_BITS - 1) / DIV_BITS;
    localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    // Radix limits and divisor width (bases 2 to 16)
    localparam int MIN_BASE  = 2;
    localparam int MAX_BASE  = 16;
    localparam int DIVISOR_W = 5;
    localparam int DIGIT_W   = 4;

    // Character codes
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_NONE  = 8'h00;

    typedef struct packed {
        logic [31:0] value;
        logic [7:0]  base;
        logic        signed_mode;
    } num_beat_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
        logic       no_text;
    } chr_beat_t;

    // Divider status back to the sequencer
    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [WORD_BITS-1:0] quo;
        logic [DIGIT_W-1:0]   rem;
    } div_rsp_t;

    // Map a digit value to its ASCII character
    function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [7:0] d8;
        d8 = {{(8 - DIGIT_W){1'b0}}, d};
        if (d8 < 8'd10)
            return CHAR_ZERO + d8;
        else
            return CHAR_A + (d8 - 8'd10);
    endfunction

endpackage

`default_nettype wire

@@ design/iar_div.sv @@
`default_nettype none

// Iterative long divider: a word by a small divisor, DIV_BITS quotient bits per cycle while busy.
module iar_div (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [iar_pkg::WORD_BITS-1:0]       dividend,
    input  wire logic [iar_pkg::DIVISOR_W-1:0]       divisor,
    output iar_pkg::div_rsp_t                        rsp
);
    import iar_pkg::*;

    logic [WORD_BITS-1:0] quo_reg,  quo_next;
    logic [DIVISOR_W-1:0] rem_reg,  rem_next;
    logic [STEP_W-1:0]    step_reg;
    logic                 busy_reg;
    logic                 done_reg;

    // Shift DIV_BITS dividend bits through the partial remainder
    always_comb
    begin
        logic [DIVISOR_W:0]   r;
        logic [WORD_BITS-1:0] q;
        logic [DIVISOR_W-1:0] rr;
        q  = quo_reg;
        rr = rem_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            r = {rr, q[WORD_BITS-1]};
            q = {q[WORD_BITS-2:0], 1'b0};
            if (r >= {1'b0, divisor})
            begin
                r    = r - {1'b0, divisor};
                q[0] = 1'b1;
            end
            rr = r[DIVISOR_W-1:0];
        end
        quo_next = q;
        rem_next = rr;
    end

    // Load on start, then advance one step per cycle while busy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            step_reg <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Hold the datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg[DIGIT_W-1:0];

endmodule

`default_nettype wire

@@ design/integer_to_ascii_radix.sv @@
`default_nettype none

// Converts one 32-bit word to ASCII text in base 2 to 16, most significant digit
// first, one character per beat on the chr channel, last set on the final one.
// A negative value in signed mode prints a leading '-' and the magnitude; zero or an
// unsigned bad base (0, 1, above 16) prints '0'; a signed bad base gives one beat
// with char_code 0, last and no_text set. The block takes one number at a time:
// num_ready is high only when idle. Each digit takes one pass of the shared
// 8-bit-per-cycle divider and is written into the digit store, and each digit
// character is read back through the store's registered read before it is emitted.
module integer_to_ascii_radix (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               num_valid,
    output      logic               num_ready,
    input  wire iar_pkg::num_beat_t num,
    output      logic               chr_valid,
    input  wire logic               chr_ready,
    output      iar_pkg::chr_beat_t chr
);
    import iar_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_PUT      = 3'd1;
    localparam logic [2:0] S_DIV_GO   = 3'd2;
    localparam logic [2:0] S_DIV_WAIT = 3'd3;
    localparam logic [2:0] S_RD       = 3'd4;
    localparam logic [2:0] S_EMIT     = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [DIVISOR_W-1:0] base_reg,  base_next;
    logic [WORD_BITS-1:0] rquo_reg,  rquo_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     idx_reg,   idx_next;
    chr_beat_t            pend_reg,  pend_next;
    chr_beat_t            out_reg,   out_next;
    logic                 out_valid_reg, out_valid_next;

    logic [DIGIT_W-1:0]   digit_mem [MAX_DIGITS];
    logic [DIGIT_W-1:0]   rd_reg;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic                 div_start;
    div_rsp_t             div_rsp;
    logic                 slot_free;
    logic [CNT_W-1:0]     count_inc;

    iar_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rquo_reg),
        .divisor  (base_reg),
        .rsp      (div_rsp)
    );

    assign num_ready = (state_reg == S_IDLE);
    assign chr_valid = out_valid_reg;
    assign chr       = out_reg;
    assign slot_free = !out_valid_reg || chr_ready;
    assign count_inc = count_reg + 1'b1;
    assign div_start = (state_reg == S_DIV_GO);
    assign wr_en     = (state_reg == S_DIV_WAIT) && div_rsp.done;
    assign rd_addr   = IDX_W'(idx_reg - 1'b1);

    // Sequencer
    always_comb
    begin
        logic                 bad_base;
        logic                 neg;
        logic [WORD_BITS-1:0] mag;
        state_next     = state_reg;
        base_next      = base_reg;
        rquo_next      = rquo_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !chr_ready;
        bad_base = (num.base < 8'(MIN_BASE)) || (num.base > 8'(MAX_BASE));
        neg      = num.signed_mode && num.value[WORD_BITS-1];
        mag      = neg ? (~num.value[WORD_BITS-1:0] + 1'b1) : num.value[WORD_BITS-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (num_valid)
                begin
                    base_next  = num.base[DIVISOR_W-1:0];
                    rquo_next  = mag;
                    count_next = '0;
                    if (bad_base)
                    begin
                        pend_next.char_code = num.signed_mode ? CHAR_NONE : CHAR_ZERO;
                        pend_next.last      = 1'b1;
                        pend_next.no_text   = num.signed_mode;
                        state_next          = S_PUT;
                    end
                    else if (neg)
                    begin
                        pend_next.char_code = CHAR_MINUS;
                        pend_next.last      = 1'b0;
                        pend_next.no_text   = 1'b0;
                        state_next          = S_PUT;
                    end
                    else if (mag == '0)
                    begin
                        pend_next.char_code = CHAR_ZERO;
                        pend_next.last      = 1'b1;
                        pend_next.no_text   = 1'b0;
                        state_next          = S_PUT;
                    end
                    else
                    begin
                        state_next = S_DIV_GO;
                    end
                end
            end
            S_PUT:
            begin
                if (slot_free)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = pend_reg.last ? S_IDLE : S_DIV_GO;
                end
            end
            S_DIV_GO:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    count_next = count_inc;
                    rquo_next  = div_rsp.quo;
                    if ((div_rsp.quo == '0) || (count_inc == CNT_W'(MAX_DIGITS)))
                    begin
                        idx_next   = count_inc;
                        state_next = S_RD;
                    end
                    else
                    begin
                        state_next = S_DIV_GO;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_next.char_code = digit_char(rd_reg);
                    out_next.last      = (idx_reg == CNT_W'(1));
                    out_next.no_text   = 1'b0;
                    out_valid_next     = 1'b1;
                    idx_next           = idx_reg - 1'b1;
                    state_next         = (idx_reg == CNT_W'(1)) ? S_IDLE : S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rquo_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rquo_reg      <= rquo_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    // Digit store: write on each finished division, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            digit_mem[count_reg[IDX_W-1:0]] <= div_rsp.rem;
        rd_reg <= digit_mem[rd_addr];
    end

`ifndef SYNTHESIS
    a_accept_drops_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (num_valid && num_ready) |=> !num_ready)
        else $error("num_ready still high after an accepted beat");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV_WAIT))
        else $error("divider finished outside the wait state");

    a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> ((idx_reg != '0) && (idx_reg <= CNT_W'(MAX_DIGITS))))
        else $error("digit index out of range while emitting");

    a_idle_divider: assert property (@(posedge clk) disable iff (!rst_n)
        num_ready |-> !div_rsp.busy)
        else $error("divider busy while idle");
`endif

endmodule

`default_nettype wire

@@ tb/tb_integer_to_ascii_radix.sv @@
`default_nettype none

module tb_integer_to_ascii_radix;

    timeunit 1ns;
    timeprecision 1ps;

    import iar_pkg::*;

    localparam int RANDOM_ITEMS = 360;
    localparam int PAUSE_AT     = 120;
    localparam int HOLD_AT      = 200;
    localparam int CALM_FROM    = 320;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 1500000;

    // How a directed row gets its expected text
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_TEXT,
        ROW_NO_TEXT
    } row_kind_e;

    logic      clk;
    logic      rst_n;
    logic      num_valid;
    logic      num_ready;
    num_beat_t num;
    logic      chr_valid;
    logic      chr_ready;
    chr_beat_t chr;

    chr_beat_t   text_due[$];
    int          fail_count;
    int unsigned cycle_count;
    bit          calm;
    bit          hold_req;

    num_beat_t   dir_num[$];
    row_kind_e   dir_kind[$];
    string       dir_text[$];

    integer_to_ascii_radix i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .num_valid (num_valid),
        .num_ready (num_ready),
        .num       (num),
        .chr_valid (chr_valid),
        .chr_ready (chr_ready),
        .chr       (chr)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Queue one expected character beat
    function automatic void put_char(input logic [7:0] c, input logic l, input logic nt);
        chr_beat_t b;
        b.char_code = c;
        b.last      = l;
        b.no_text   = nt;
        text_due.push_back(b);
    endfunction

    // Spell one number in its base, most significant digit first; a bad base gets its single beat
    function automatic void spell_number(input num_beat_t n);
        logic [WORD_BITS-1:0] mag;
        logic [WORD_BITS-1:0] quo;
        logic [WORD_BITS-1:0] rem;
        logic [3:0]           digs[MAX_DIGITS];
        logic [7:0]           d8;
        int                   cnt;
        int                   i;
        bit                   bad;
        bad = (n.base < MIN_BASE) || (n.base > MAX_BASE);
        if (bad)
        begin
            if (n.signed_mode)
                put_char(CHAR_NONE, 1'b1, 1'b1);
            else
                put_char(CHAR_ZERO, 1'b1, 1'b0);
            return;
        end
        mag = n.value[WORD_BITS-1:0];
        if (n.signed_mode && mag[WORD_BITS-1])
        begin
            put_char(CHAR_MINUS, 1'b0, 1'b0);
            mag = ~mag + 1'b1;
        end
        if (mag == '0)
        begin
            put_char(CHAR_ZERO, 1'b1, 1'b0);
            return;
        end
        // Collect digits low first, then emit them reversed
        cnt = 0;
        quo = mag;
        while (quo != '0 && cnt < MAX_DIGITS)
        begin
            rem = quo % {{(WORD_BITS - 8){1'b0}}, n.base};
            digs[cnt] = rem[3:0];
            cnt++;
            quo = quo / {{(WORD_BITS - 8){1'b0}}, n.base};
        end
        for (i = cnt - 1; i >= 0; i--)
        begin
            d8 = {4'd0, digs[i]};
            if (d8 < 8'd10)
                put_char(CHAR_ZERO + d8, i == 0, 1'b0);
            else
                put_char(CHAR_A + (d8 - 8'd10), i == 0, 1'b0);
        end
    endfunction

    function automatic num_beat_t pick_number();
        num_beat_t   n;
        logic [31:0] p;
        int          k;
        int          b;
        // Mostly valid bases, some bad ones across the whole byte
        k = $urandom_range(0, 19);
        if (k == 0)
            n.base = 8'($urandom_range(0, 1));
        else if (k == 1)
            n.base = 8'($urandom_range(17, 255));
        else
            n.base = 8'($urandom_range(MIN_BASE, MAX_BASE));
        n.signed_mode = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: n.value = $urandom();
            4, 5:       n.value = 32'($urandom_range(0, 40));
            6:          n.value = -32'($urandom_range(1, 40));
            7:
            begin
                case ($urandom_range(0, 3))
                    0:       n.value = 32'h0000_0000;
                    1:       n.value = 32'hFFFF_FFFF;
                    2:       n.value = 32'h8000_0000;
                    default: n.value = 32'h7FFF_FFFF;
                endcase
            end
            8:
            begin
                // Land near a power of the base, where digit counts change
                b = (n.base < MIN_BASE || n.base > MAX_BASE) ? 10 : int'(n.base);
                p = 32'd1;
                k = $urandom_range(1, 20);
                repeat (k) p = p * b;
                n.value = p + 32'($urandom_range(0, 2)) - 32'd1;
            end
            default:    n.value = $urandom() >> $urandom_range(0, 31);
        endcase
        return n;
    endfunction

    function automatic void add_row(input row_kind_e kind, input logic [31:0] v,
                                    input logic [7:0] b, input logic s, input string text);
        num_beat_t n;
        n.value       = v;
        n.base        = b;
        n.signed_mode = s;
        dir_num.push_back(n);
        dir_kind.push_back(kind);
        dir_text.push_back(text);
    endfunction

    // Offer one number, wait for its beat, then queue its text
    task automatic send_number(input num_beat_t n, input row_kind_e kind, input string text);
        int gap;
        int i;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 19);
            num_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        num_valid <= 1'b1;
        num       <= n;
        do
            @(posedge clk);
        while (num_ready !== 1'b1);
        case (kind)
            ROW_TEXT:
            begin
                for (i = 0; i < text.len(); i++)
                    put_char(text[i], i == text.len() - 1, 1'b0);
            end
            ROW_NO_TEXT: put_char(CHAR_NONE, 1'b1, 1'b1);
            default:     spell_number(n);
        endcase
    endtask

    // Receiver: check each accepted beat, stall in bursts, hold off on request
    initial
    begin
        chr_beat_t want;
        int        stall_left;
        int        hold_left;
        chr_ready  = 1'b0;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (chr_valid === 1'b1 && chr_ready === 1'b1)
            begin
                if (text_due.size() == 0)
                begin
                    $error("char_code: expected none, got %h", chr.char_code);
                    fail_count++;
                end
                else
                begin
                    want = text_due.pop_front();
                    if (chr.char_code !== want.char_code)
                    begin
                        $error("char_code: expected %h, got %h", want.char_code, chr.char_code);
                        fail_count++;
                    end
                    if (chr.last !== want.last)
                    begin
                        $error("last: expected %b, got %b", want.last, chr.last);
                        fail_count++;
                    end
                    if (chr.no_text !== want.no_text)
                    begin
                        $error("no_text: expected %b, got %b", want.no_text, chr.no_text);
                        fail_count++;
                    end
                end
            end
            if (rst_n !== 1'b1)
                chr_ready <= 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                chr_ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                chr_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                chr_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                chr_ready <= 1'b0;
            end
            else
                chr_ready <= 1'b1;
        end
    end

    // Bound the run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** integer_to_ascii_radix: FAILED **");
        $finish;
    end

    initial
    begin
        int i;
        rst_n      = 1'b0;
        num_valid  = 1'b0;
        num        = '0;
        fail_count = 0;
        calm       = 1'b0;
        hold_req   = 1'b0;

        // Directed rows: extremes, signs, bad bases, digit rollovers
        add_row(ROW_TEXT,    32'h0000_0000, 8'd10,  1'b0, "0");
        add_row(ROW_TEXT,    32'hFFFF_FFFF, 8'd16,  1'b0, "FFFFFFFF");
        add_row(ROW_TEXT,    32'hFFFF_FFFF, 8'd2,   1'b0, "11111111111111111111111111111111");
        add_row(ROW_TEXT,    32'hFFFF_FFFF, 8'd10,  1'b0, "4294967295");
        add_row(ROW_TEXT,    32'hFFFF_FFFF, 8'd10,  1'b1, "-1");
        add_row(ROW_TEXT,    32'h8000_0000, 8'd10,  1'b1, "-2147483648");
        add_row(ROW_TEXT,    32'h7FFF_FFFF, 8'd10,  1'b1, "2147483647");
        add_row(ROW_TEXT,    32'h8000_0000, 8'd16,  1'b1, "-80000000");
        add_row(ROW_TEXT,    32'h0000_0000, 8'd10,  1'b1, "0");
        add_row(ROW_TEXT,    32'h0000_0005, 8'd0,   1'b0, "0");
        add_row(ROW_TEXT,    32'h0000_0005, 8'd1,   1'b0, "0");
        add_row(ROW_TEXT,    32'h0000_0005, 8'd17,  1'b0, "0");
        add_row(ROW_TEXT,    32'hFFFF_FFFF, 8'd255, 1'b0, "0");
        add_row(ROW_NO_TEXT, 32'h0000_0005, 8'd0,   1'b1, "");
        add_row(ROW_NO_TEXT, 32'h0000_0005, 8'd1,   1'b1, "");
        add_row(ROW_NO_TEXT, 32'hFFFF_FFFF, 8'd255, 1'b1, "");
        add_row(ROW_NO_TEXT, 32'h0000_0000, 8'd17,  1'b1, "");
        add_row(ROW_TEXT,    32'hFFFF_FFFF, 8'd2,   1'b1, "-1");
        add_row(ROW_PREDICT, 32'h8000_0000, 8'd2,   1'b1, "");
        add_row(ROW_TEXT,    32'h0000_000F, 8'd16,  1'b0, "F");
        add_row(ROW_TEXT,    32'h0000_0010, 8'd16,  1'b0, "10");
        add_row(ROW_TEXT,    32'h0000_0009, 8'd9,   1'b0, "10");
        add_row(ROW_PREDICT, 32'hDEAD_BEEF, 8'd7,   1'b0, "");
        add_row(ROW_PREDICT, 32'h1234_5678, 8'd3,   1'b1, "");
        add_row(ROW_PREDICT, 32'hABCD_EF01, 8'd13,  1'b1, "");

        // Hold reset, release on an edge
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < dir_num.size(); i++)
            send_number(dir_num[i], dir_kind[i], dir_text[i]);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == PAUSE_AT)
            begin
                // Drop valid and let the output side drain completely
                num_valid <= 1'b0;
                @(posedge clk);
                while (text_due.size() != 0) @(posedge clk);
            end
            if (i == HOLD_AT)
                hold_req = 1'b1;
            if (i == CALM_FROM)
                calm = 1'b1;
            send_number(pick_number(), ROW_PREDICT, "");
        end
        num_valid <= 1'b0;

        // Drain outstanding text, then allow for trailing beats
        while (text_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("** integer_to_ascii_radix: PASSED **");
        else
            $display("** integer_to_ascii_radix: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
